### design/gdad_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date adder.
// Used by gdad_ucode, gdad_dpath and gregorian_date_add_days; no dependencies.
`default_nettype none

package gdad_pkg;

  // Year limits of the supported calendar range.
  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // Month numbers that the logic refers to by name.
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Year lengths in days.
  localparam logic [8:0] DAYS_COMMON = 9'd365;
  localparam logic [8:0] DAYS_LEAP   = 9'd366;

  // floor(y / 100) equals (y * DIV100_MUL) >> DIV100_SHIFT for every 14-bit y.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [7:0]  CENTURY      = 8'd100;
  localparam logic [6:0]  LAST_IN_CENT = 7'd99;

  // Month lengths of a common year, January first.
  localparam logic [4:0] MONTH_LEN [0:11] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_MOD,
    OP_SETERR,
    OP_ADDMON,
    OP_ADDOFF,
    OP_YFWD,
    OP_YBACK,
    OP_SUBMON,
    OP_EMIT
  } op_t;

  // Jump conditions tested by the sequencer.
  typedef enum logic [3:0] {
    C_TRUE,
    C_IN_VALID,
    C_BAD_DATE,
    C_MLT,
    C_OVER_OK,
    C_OVER,
    C_UNDER_OK,
    C_UNDER,
    C_MWALK,
    C_OUT_FREE
  } cond_t;

  // One microcode word: the operation runs only when the condition holds.
  typedef struct packed {
    cond_t      cond;
    op_t        op;
    logic [3:0] next_t;
    logic [3:0] next_f;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic en;
    op_t  op;
  } ctrl_t;

  // Condition flags from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic bad_date;
    logic mlt;
    logic over_ok;
    logic over;
    logic under_ok;
    logic under;
    logic mwalk;
    logic out_free;
  } status_t;

  // Leap rule from the year's low bits, its remainder mod 100 and its century mod 4.
  function automatic logic is_leap(input logic [1:0] ylo, input logic [6:0] rem100,
                                   input logic [1:0] cent4);
    is_leap = ((rem100 != 7'd0) && (ylo == 2'd0)) || ((rem100 == 7'd0) && (cent4 == 2'd0));
  endfunction

  // Number of days in a month; a month code outside 1..12 gives zero.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    logic [4:0] d;
    idx = m - MONTH_JAN;
    if ((m < MONTH_JAN) || (m > MONTH_DEC)) begin
      d = 5'd0;
    end else begin
      d = MONTH_LEN[idx];
    end
    if ((m == MONTH_FEB) && leap) begin
      d = d + 5'd1;
    end
    month_days = d;
  endfunction

  // Number of days in a year.
  function automatic logic [8:0] year_days(input logic leap);
    year_days = leap ? DAYS_LEAP : DAYS_COMMON;
  endfunction

endpackage

`default_nettype wire

### design/gregorian_date_add_days.sv
// After acceptance: DIV, MOD, CHECK, the month sum up to start_month, the offset add, the
// forward and backward year loops, the month walk to result_month and OUT to out_valid; an
// invalid date goes from CHECK straight to OUT. Throughput: one transaction at a time; a new
// one can be taken as out_valid rises, and the year loop crosses about 2871 years at most.
// A finished result waits in the output register while the next transaction is taken.
// Reset: synchronous, active high; returns the sequencer to idle and clears out_valid.
`default_nettype none

module gregorian_date_add_days (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [4:0]         start_day,
  input  wire logic [3:0]         start_month,
  input  wire logic [13:0]        start_year,
  input  wire logic signed [20:0] day_offset,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [4:0]              result_day,
  output logic [3:0]              result_month,
  output logic [13:0]             result_year,
  output logic                    date_error
);

  gdad_pkg::ctrl_t   ctrl;
  gdad_pkg::status_t status;

  // Program sequencer.
  gdad_ucode u_ucode (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  // Calendar datapath and result register.
  gdad_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .in_valid     (in_valid),
    .start_day    (start_day),
    .start_month  (start_month),
    .start_year   (start_year),
    .day_offset   (day_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_day   (result_day),
    .result_month (result_month),
    .result_year  (result_year),
    .date_error   (date_error)
  );

endmodule

`default_nettype wire

### design/gdad_ucode.sv
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on gdad_pkg for the control word, operation and condition types.
`default_nettype none

module gdad_ucode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire gdad_pkg::status_t status,
  output gdad_pkg::ctrl_t      ctrl,
  output logic                 in_stall
);

  // Step addresses of the program.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_MOD    = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_MSUM   = 4'd4;
  localparam logic [3:0] S_OFFS   = 4'd5;
  localparam logic [3:0] S_FWD    = 4'd6;
  localparam logic [3:0] S_FWDERR = 4'd7;
  localparam logic [3:0] S_BACK   = 4'd8;
  localparam logic [3:0] S_BKERR  = 4'd9;
  localparam logic [3:0] S_MWALK  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0]       step;
  logic [3:0]       step_next;
  gdad_pkg::ucode_t word;
  logic             taken;

  // Control store.
  always_comb begin
    unique case (step)
      S_IDLE:   word = '{gdad_pkg::C_IN_VALID, gdad_pkg::OP_LOAD,   S_DIV,    S_IDLE};
      S_DIV:    word = '{gdad_pkg::C_TRUE,     gdad_pkg::OP_DIV,    S_MOD,    S_MOD};
      S_MOD:    word = '{gdad_pkg::C_TRUE,     gdad_pkg::OP_MOD,    S_CHECK,  S_CHECK};
      S_CHECK:  word = '{gdad_pkg::C_BAD_DATE, gdad_pkg::OP_SETERR, S_OUT,    S_MSUM};
      S_MSUM:   word = '{gdad_pkg::C_MLT,      gdad_pkg::OP_ADDMON, S_MSUM,   S_OFFS};
      S_OFFS:   word = '{gdad_pkg::C_TRUE,     gdad_pkg::OP_ADDOFF, S_FWD,    S_FWD};
      S_FWD:    word = '{gdad_pkg::C_OVER_OK,  gdad_pkg::OP_YFWD,   S_FWD,    S_FWDERR};
      S_FWDERR: word = '{gdad_pkg::C_OVER,     gdad_pkg::OP_SETERR, S_OUT,    S_BACK};
      S_BACK:   word = '{gdad_pkg::C_UNDER_OK, gdad_pkg::OP_YBACK,  S_BACK,   S_BKERR};
      S_BKERR:  word = '{gdad_pkg::C_UNDER,    gdad_pkg::OP_SETERR, S_OUT,    S_MWALK};
      S_MWALK:  word = '{gdad_pkg::C_MWALK,    gdad_pkg::OP_SUBMON, S_MWALK,  S_OUT};
      S_OUT:    word = '{gdad_pkg::C_OUT_FREE, gdad_pkg::OP_EMIT,   S_IDLE,   S_OUT};
      default:  word = '{gdad_pkg::C_TRUE,     gdad_pkg::OP_NOP,    S_IDLE,   S_IDLE};
    endcase
  end

  // Condition select.
  always_comb begin
    unique case (word.cond)
      gdad_pkg::C_TRUE:     taken = 1'b1;
      gdad_pkg::C_IN_VALID: taken = status.in_valid;
      gdad_pkg::C_BAD_DATE: taken = status.bad_date;
      gdad_pkg::C_MLT:      taken = status.mlt;
      gdad_pkg::C_OVER_OK:  taken = status.over_ok;
      gdad_pkg::C_OVER:     taken = status.over;
      gdad_pkg::C_UNDER_OK: taken = status.under_ok;
      gdad_pkg::C_UNDER:    taken = status.under;
      gdad_pkg::C_MWALK:    taken = status.mwalk;
      gdad_pkg::C_OUT_FREE: taken = status.out_free;
      default:              taken = 1'b0;
    endcase
  end

  // The operation of a step runs only on the taken branch.
  assign ctrl.en   = taken;
  assign ctrl.op   = word.op;
  assign step_next = taken ? word.next_t : word.next_f;
  assign in_stall  = (step != S_IDLE);

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

### design/gdad_dpath.sv
// Datapath of the date adder: date registers, day-of-year accumulator and result register.
// Depends on gdad_pkg; driven by the control words of gdad_ucode.
`default_nettype none

module gdad_dpath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gdad_pkg::ctrl_t     ctrl,
  output gdad_pkg::status_t        status,
  input  wire logic                in_valid,
  input  wire logic [4:0]          start_day,
  input  wire logic [3:0]          start_month,
  input  wire logic [13:0]         start_year,
  input  wire logic signed [20:0]  day_offset,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [4:0]               result_day,
  output logic [3:0]               result_month,
  output logic [13:0]              result_year,
  output logic                     date_error
);

  logic [4:0]         sday;
  logic [3:0]         smonth;
  logic [13:0]        year;
  logic signed [20:0] offset;
  logic signed [21:0] doy;
  logic [3:0]         mon;
  logic [7:0]         q;
  logic [6:0]         r100;
  logic [1:0]         q4;
  logic               err;

  logic [26:0]        div_prod;
  logic [13:0]        rem_full;
  logic               leap_cur;
  logic               leap_prev;
  logic [6:0]         r100_prev;
  logic [1:0]         q4_prev;
  logic [13:0]        year_prev;
  logic [8:0]         ylen_cur;
  logic [8:0]         ylen_prev;
  logic [4:0]         dim_start;
  logic [4:0]         dim_mon;
  logic signed [21:0] ylen_cur_s;
  logic signed [21:0] ylen_prev_s;
  logic signed [21:0] dim_mon_s;

  // Century split of the year: quotient by reciprocal multiply, then remainder.
  assign div_prod = 27'(year) * 27'(gdad_pkg::DIV100_MUL);
  assign rem_full = year - 14'(q * gdad_pkg::CENTURY);

  // Leap status of the current year and of the year before it.
  assign r100_prev = (r100 == 7'd0) ? gdad_pkg::LAST_IN_CENT : r100 - 7'd1;
  assign q4_prev   = (r100 == 7'd0) ? q4 - 2'd1 : q4;
  assign year_prev = year - 14'd1;
  assign leap_cur  = gdad_pkg::is_leap(year[1:0], r100, q4);
  assign leap_prev = gdad_pkg::is_leap(year_prev[1:0], r100_prev, q4_prev);

  assign ylen_cur    = gdad_pkg::year_days(leap_cur);
  assign ylen_prev   = gdad_pkg::year_days(leap_prev);
  assign dim_start   = gdad_pkg::month_days(smonth, leap_cur);
  assign dim_mon     = gdad_pkg::month_days(mon, leap_cur);
  assign ylen_cur_s  = $signed({13'd0, ylen_cur});
  assign ylen_prev_s = $signed({13'd0, ylen_prev});
  assign dim_mon_s   = $signed({17'd0, dim_mon});

  // Condition flags for the sequencer.
  always_comb begin
    status.in_valid = in_valid;
    status.bad_date = (smonth < gdad_pkg::MONTH_JAN) || (smonth > gdad_pkg::MONTH_DEC) ||
                      (year < gdad_pkg::YEAR_MIN) || (year > gdad_pkg::YEAR_MAX) ||
                      (sday == 5'd0) || (sday > dim_start);
    status.mlt      = (mon < smonth);
    status.over     = (doy > ylen_cur_s);
    status.over_ok  = status.over && (year < gdad_pkg::YEAR_MAX);
    status.under    = doy[21] || (doy == 22'sd0);
    status.under_ok = status.under && (year > gdad_pkg::YEAR_MIN);
    status.mwalk    = (mon < gdad_pkg::MONTH_DEC) && (doy > dim_mon_s);
    status.out_free = !out_valid || !out_stall;
  end

  // Register updates selected by the control word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      err       <= 1'b0;
    end else begin
      // The result register empties when taken, unless a new result lands in the same cycle.
      if (out_valid && !out_stall &&
          !(ctrl.en && (ctrl.op == gdad_pkg::OP_EMIT))) begin
        out_valid <= 1'b0;
      end
      if (ctrl.en) begin
        case (ctrl.op)
          gdad_pkg::OP_LOAD: begin
            sday   <= start_day;
            smonth <= start_month;
            year   <= start_year;
            offset <= day_offset;
            err    <= 1'b0;
          end
          gdad_pkg::OP_DIV: begin
            q <= div_prod[gdad_pkg::DIV100_SHIFT +: 8];
          end
          gdad_pkg::OP_MOD: begin
            r100 <= rem_full[6:0];
            q4   <= q[1:0];
            doy  <= $signed({17'd0, sday});
            mon  <= gdad_pkg::MONTH_JAN;
          end
          gdad_pkg::OP_SETERR: begin
            err <= 1'b1;
          end
          gdad_pkg::OP_ADDMON: begin
            doy <= doy + $signed({17'd0, gdad_pkg::month_days(mon, leap_cur)});
            mon <= mon + 4'd1;
          end
          gdad_pkg::OP_ADDOFF: begin
            doy <= doy + {offset[20], offset};
            mon <= gdad_pkg::MONTH_JAN;
          end
          gdad_pkg::OP_YFWD: begin
            doy  <= doy - ylen_cur_s;
            year <= year + 14'd1;
            if (r100 == gdad_pkg::LAST_IN_CENT) begin
              r100 <= 7'd0;
              q4   <= q4 + 2'd1;
            end else begin
              r100 <= r100 + 7'd1;
            end
          end
          gdad_pkg::OP_YBACK: begin
            doy  <= doy + ylen_prev_s;
            year <= year_prev;
            r100 <= r100_prev;
            q4   <= q4_prev;
          end
          gdad_pkg::OP_SUBMON: begin
            doy <= doy - dim_mon_s;
            mon <= mon + 4'd1;
          end
          gdad_pkg::OP_EMIT: begin
            out_valid    <= 1'b1;
            result_day   <= err ? 5'd0 : doy[4:0];
            result_month <= err ? 4'd0 : mon;
            result_year  <= err ? 14'd0 : year;
            date_error   <= err;
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTH
  // A good result always names a real month and a non-zero day.
  a_good_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !date_error) |->
      ((result_month >= gdad_pkg::MONTH_JAN) && (result_month <= gdad_pkg::MONTH_DEC) &&
       (result_day != 5'd0)))
    else $error("valid result with impossible month or day");

  // A flagged result carries zero date fields.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && date_error) |->
      ((result_day == 5'd0) && (result_month == 4'd0) && (result_year == 14'd0)))
    else $error("error result with non-zero fields");

  // Stepping forward never carries the year past the top of the range.
  a_fwd_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.en && (ctrl.op == gdad_pkg::OP_YFWD)) |=>
      ((year <= gdad_pkg::YEAR_MAX) && (r100 <= gdad_pkg::LAST_IN_CENT)))
    else $error("forward year step left the range");

  // Stepping back never takes the year below one, and the remainder stays consistent.
  a_back_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.en && (ctrl.op == gdad_pkg::OP_YBACK)) |=>
      ((year >= gdad_pkg::YEAR_MIN) && (r100 <= gdad_pkg::LAST_IN_CENT)))
    else $error("backward year step left the range");
`endif

endmodule

`default_nettype wire
